FILE: hw/rtl/psca_pkg.sv
package psca_pkg;

    // field widths of the request and result ports
    localparam int unsigned W_CMD    = 2;
    localparam int unsigned W_SEL    = 3;
    localparam int unsigned W_PID    = 8;
    localparam int unsigned W_BYTES  = 20;
    localparam int unsigned W_STATUS = 2;
    localparam int unsigned W_ADDR21 = 21;
    localparam int unsigned W_ADDR22 = 22;

    localparam logic [W_ADDR21-1:0] MAX21 = '1;
    localparam logic [W_ADDR22-1:0] MAX22 = '1;

    // capacity register reset value
    localparam logic [W_BYTES-1:0] CAP_RESET = 20'd262144;

    // command codes
    localparam logic [W_CMD-1:0] CMD_SET   = 2'd0;
    localparam logic [W_CMD-1:0] CMD_WRITE = 2'd1;
    localparam logic [W_CMD-1:0] CMD_QUERY = 2'd2;

    // status codes
    localparam logic [W_STATUS-1:0] ST_OK      = 2'd0;
    localparam logic [W_STATUS-1:0] ST_INVALID = 2'd1;
    localparam logic [W_STATUS-1:0] ST_BUSY    = 2'd2;
    localparam logic [W_STATUS-1:0] ST_FAILED  = 2'd3;

    // what the datapath does with the table word read in the previous cycle
    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_SUM  = 2'd1,
        TAG_SEL  = 2'd2,
        TAG_ADJ  = 2'd3
    } t_tag;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        t_tag tag;
        logic decide;
        logic commit;
        logic strobe;
    } t_ctrl;

    // status from datapath to controller
    typedef struct packed {
        logic idx_last;
        logic need_adj;
    } t_stat;

endpackage

FILE: hw/rtl/program_slot_compacting_allocator.sv
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+--------------------------------------
// request   | in        | start high, busy low          | cmd, slot, id, running, offset, count
// result    | out       | o_strobe, one cycle, no stall | status, move, write addr, extents
// config    | in        | i_cfg_valid and o_cfg_ready   | program capacity
//
// a request sweeps the table for the size sum, reads its target entry and decides; when a
// freed slot forces compaction it sweeps again to adjust offsets. both sweeps share the
// single table read port, swept once for the size sum and once for the offset adjustment.
// busy stays high until the result cycle ends.
// reset is synchronous, active low, and clears the table through valid bits.
// the capacity register is always ready; results cannot be stalled.
module program_slot_compacting_allocator #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned ADDR_BITS  = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [psca_pkg::W_CMD-1:0]        i_cmd,
    input  logic [psca_pkg::W_SEL-1:0]        i_selected_slot,
    input  logic [psca_pkg::W_PID-1:0]        i_program_id,
    input  logic                              i_program_running,
    input  logic [psca_pkg::W_BYTES-1:0]      i_byte_offset,
    input  logic [psca_pkg::W_BYTES-1:0]      i_byte_count,
    output logic                              o_strobe,
    output logic [psca_pkg::W_STATUS-1:0]     o_status,
    output logic [psca_pkg::W_ADDR21-1:0]     o_move_source,
    output logic [psca_pkg::W_ADDR21-1:0]     o_move_dest,
    output logic [psca_pkg::W_ADDR21-1:0]     o_move_length,
    output logic [psca_pkg::W_ADDR21-1:0]     o_write_address,
    output logic [psca_pkg::W_ADDR21-1:0]     o_span_start,
    output logic [psca_pkg::W_ADDR22-1:0]     o_span_end,
    output logic [psca_pkg::W_ADDR22-1:0]     o_free_start,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psca_pkg::W_BYTES-1:0]      i_cfg_data
);
    import psca_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  ctrl_busy;

    // sequencer
    psca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (ctrl_busy)
    );

    // slot table and arithmetic
    psca_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_selected_slot   (i_selected_slot),
        .i_program_id      (i_program_id),
        .i_program_running (i_program_running),
        .i_byte_offset     (i_byte_offset),
        .i_byte_count      (i_byte_count),
        .o_status          (o_status),
        .o_move_source     (o_move_source),
        .o_move_dest       (o_move_dest),
        .o_move_length     (o_move_length),
        .o_write_address   (o_write_address),
        .o_span_start      (o_span_start),
        .o_span_end        (o_span_end),
        .o_free_start      (o_free_start)
    );

    assign busy        = ctrl_busy;
    assign o_strobe    = ctrl.strobe;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: hw/rtl/psca_ctrl.sv
module psca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  psca_pkg::t_stat i_stat,
    output psca_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);
    import psca_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SUM    = 9'b000000010,
        S_SEL    = 9'b000000100,
        S_WAIT   = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_ADJ    = 9'b000100000,
        S_ADJL   = 9'b001000000,
        S_FIN    = 9'b010000000,
        S_RESP   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_ctrl  c;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencing of the passes over the table
    always_comb begin
        n_state = r_state;
        c       = '0;
        c.tag   = TAG_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    c.load    = 1'b1;
                    c.idx_clr = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                c.tag     = TAG_SUM;
                c.idx_inc = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                c.tag   = TAG_SEL;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                c.decide  = 1'b1;
                c.idx_clr = 1'b1;
                n_state   = i_stat.need_adj ? S_ADJ : S_FIN;
            end
            S_ADJ: begin
                c.tag     = TAG_ADJ;
                c.idx_inc = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_ADJL;
                end
            end
            S_ADJL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                c.commit = 1'b1;
                n_state  = S_RESP;
            end
            S_RESP: begin
                c.strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctrl = c;
    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/psca_dpath.sv
module psca_dpath #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned ADDR_BITS  = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  psca_pkg::t_ctrl                   i_ctrl,
    output psca_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_valid,
    input  logic [psca_pkg::W_BYTES-1:0]      i_cfg_data,
    input  logic [psca_pkg::W_CMD-1:0]        i_cmd,
    input  logic [psca_pkg::W_SEL-1:0]        i_selected_slot,
    input  logic [psca_pkg::W_PID-1:0]        i_program_id,
    input  logic                              i_program_running,
    input  logic [psca_pkg::W_BYTES-1:0]      i_byte_offset,
    input  logic [psca_pkg::W_BYTES-1:0]      i_byte_count,
    output logic [psca_pkg::W_STATUS-1:0]     o_status,
    output logic [psca_pkg::W_ADDR21-1:0]     o_move_source,
    output logic [psca_pkg::W_ADDR21-1:0]     o_move_dest,
    output logic [psca_pkg::W_ADDR21-1:0]     o_move_length,
    output logic [psca_pkg::W_ADDR21-1:0]     o_write_address,
    output logic [psca_pkg::W_ADDR21-1:0]     o_span_start,
    output logic [psca_pkg::W_ADDR22-1:0]     o_span_end,
    output logic [psca_pkg::W_ADDR22-1:0]     o_free_start
);
    import psca_pkg::*;

    localparam int unsigned SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned AW1 = ADDR_BITS + 1;
    localparam int unsigned TW  = AW1 + $clog2(SLOT_COUNT + 1);
    localparam int unsigned WW  = (TW + 1 > 23) ? TW + 1 : 23;
    localparam logic [W_PID-1:0] NSLOT = W_PID'(SLOT_COUNT);
    localparam logic [SW-1:0]    LAST  = SW'(SLOT_COUNT - 1);
    localparam logic [AW1-1:0]   AMAX  = '1;

    // table storage, valid bits stand in for the reset clear
    logic [AW1-1:0]        mem_off  [SLOT_COUNT];
    logic [AW1-1:0]        mem_size [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_voff;
    logic [SLOT_COUNT-1:0] r_vsize;

    logic [SW-1:0]        r_idx;
    logic [SW-1:0]        r_recv;
    logic [W_BYTES-1:0]   r_cap;
    t_tag                 r_dtag;
    logic [SW-1:0]        r_daddr;
    logic [AW1-1:0]       r_rd_off;
    logic [AW1-1:0]       r_rd_size;
    logic [TW-1:0]        r_total;
    logic [AW1-1:0]       r_gap;
    logic [AW1-1:0]       r_off;

    logic [W_CMD-1:0]     r_cmd;
    logic [W_SEL-1:0]     r_sel;
    logic [W_PID-1:0]     r_pid;
    logic                 r_run;
    logic [W_BYTES-1:0]   r_boff;
    logic [W_BYTES-1:0]   r_bcnt;

    logic [WW-1:0]        r_rest;
    logic [AW1-1:0]       r_after_sat;
    logic [AW1-1:0]       r_new_size;
    logic                 r_do_free;
    logic                 r_do_size;

    logic [W_STATUS-1:0]  r_status;
    logic [W_ADDR21-1:0]  r_msrc;
    logic [W_ADDR21-1:0]  r_mdst;
    logic [W_ADDR21-1:0]  r_mlen;
    logic [W_ADDR21-1:0]  r_waddr;
    logic [W_ADDR21-1:0]  r_cstart;
    logic [W_ADDR22-1:0]  r_cend;
    logic [W_ADDR22-1:0]  r_fstart;

    logic [W_STATUS-1:0]  n_status;
    logic [W_ADDR21-1:0]  n_msrc;
    logic [W_ADDR21-1:0]  n_mdst;
    logic [W_ADDR21-1:0]  n_mlen;
    logic [W_ADDR21-1:0]  n_waddr;
    logic [W_ADDR21-1:0]  n_cstart;
    logic [W_ADDR22-1:0]  n_cend;
    logic [W_ADDR22-1:0]  n_fstart;
    logic                 n_do_free;
    logic                 n_do_size;

    logic [W_PID-1:0]     sel_pick;
    logic [W_PID-1:0]     tgt8;
    logic                 tgt_ok;
    logic [SW-1:0]        tgt_idx;
    logic [SW-1:0]        ra;

    logic [WW-1:0]        gap_w;
    logic [WW-1:0]        off_w;
    logic [WW-1:0]        tot_w;
    logic [WW-1:0]        after_w;
    logic [WW-1:0]        rest_w;
    logic [WW-1:0]        len_w;
    logic [WW-1:0]        wsum_w;
    logic [WW-1:0]        waddr_w;
    logic [WW-1:0]        round_w;
    logic                 shift;
    logic                 adj_hit;

    logic                 we_off;
    logic [SW-1:0]        wa_off;
    logic [AW1-1:0]       wd_off;
    logic                 we_size;
    logic [SW-1:0]        wa_size;
    logic [AW1-1:0]       wd_size;

    function automatic logic [W_ADDR21-1:0] sat21(input logic [WW-1:0] v);
        return (v > WW'(MAX21)) ? MAX21 : v[W_ADDR21-1:0];
    endfunction

    function automatic logic [W_ADDR22-1:0] sat22(input logic [WW-1:0] v);
        return (v > WW'(MAX22)) ? MAX22 : v[W_ADDR22-1:0];
    endfunction

    function automatic logic [AW1-1:0] sat_state(input logic [WW-1:0] v);
        return (v > WW'(AMAX)) ? AMAX : v[AW1-1:0];
    endfunction

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_sel  <= i_selected_slot;
            r_pid  <= i_program_id;
            r_run  <= i_program_running;
            r_boff <= i_byte_offset;
            r_bcnt <= i_byte_count;
        end
    end

    // sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctrl.idx_clr) begin
            r_idx <= '0;
        end else if (i_ctrl.idx_inc && (r_idx != LAST)) begin
            r_idx <= r_idx + SW'(1);
        end
    end

    assign o_stat.idx_last = (r_idx == LAST);

    // target slot of the request
    always_comb begin
        sel_pick = (SLOT_COUNT == 1) ? '0 : W_PID'(r_sel);
        unique case (r_cmd)
            CMD_SET: begin
                tgt8 = (r_bcnt == '0) ? sel_pick : W_PID'(r_recv);
            end
            CMD_QUERY: begin
                tgt8 = (r_pid < NSLOT) ? r_pid : sel_pick;
            end
            default: begin
                tgt8 = W_PID'(r_recv);
            end
        endcase
        tgt_ok  = (tgt8 < NSLOT);
        tgt_idx = tgt_ok ? tgt8[SW-1:0] : '0;
    end

    assign ra = (i_ctrl.tag == TAG_SEL) ? tgt_idx : r_idx;

    // table read, one address a cycle, registered
    always_ff @(posedge i_clk) begin
        r_rd_off  <= r_voff[ra]  ? mem_off[ra]  : '0;
        r_rd_size <= r_vsize[ra] ? mem_size[ra] : '0;
        r_daddr   <= ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtag <= TAG_NONE;
        end else begin
            r_dtag <= i_ctrl.tag;
        end
    end

    // size sum and capture of the target entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_total <= '0;
        end else if (r_dtag == TAG_SUM) begin
            r_total <= r_total + TW'(r_rd_size);
        end
        if (r_dtag == TAG_SEL) begin
            r_gap <= r_rd_size;
            r_off <= r_rd_off;
        end
    end

    // arithmetic on the captured entry
    always_comb begin
        gap_w   = WW'(r_gap);
        off_w   = WW'(r_off);
        tot_w   = WW'(r_total);
        after_w = tot_w - gap_w;
        rest_w  = off_w + gap_w;
        len_w   = (tot_w >= rest_w) ? (tot_w - rest_w) : '0;
        wsum_w  = off_w + WW'(r_boff) + WW'(r_bcnt);
        waddr_w = off_w + WW'(r_boff);
        round_w = (WW'(r_bcnt) + WW'(3)) & ~WW'(3);
        shift   = (r_gap != '0) && (off_w != after_w);
    end

    assign o_stat.need_adj = (r_cmd == CMD_SET) && !r_run && (r_bcnt == '0)
                             && tgt_ok && shift;

    // result and commit decision
    always_comb begin
        n_status  = ST_OK;
        n_msrc    = '0;
        n_mdst    = '0;
        n_mlen    = '0;
        n_waddr   = '0;
        n_cstart  = '0;
        n_cend    = '0;
        n_fstart  = '0;
        n_do_free = 1'b0;
        n_do_size = 1'b0;
        unique case (r_cmd)
            CMD_SET: begin
                if (r_run) begin
                    n_status = ST_BUSY;
                end else if (r_bcnt == '0) begin
                    if (!tgt_ok) begin
                        n_status = ST_INVALID;
                    end else begin
                        n_do_free = 1'b1;
                        if (shift) begin
                            n_msrc = sat21(rest_w);
                            n_mdst = sat21(off_w);
                            n_mlen = sat21(len_w);
                        end
                    end
                end else if (r_gap != '0) begin
                    n_status = ST_FAILED;
                end else begin
                    n_do_size = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (wsum_w > WW'(r_cap)) begin
                    n_status = ST_INVALID;
                end else if (r_run) begin
                    n_status = ST_BUSY;
                end else begin
                    n_waddr = sat21(waddr_w);
                end
            end
            CMD_QUERY: begin
                if (!tgt_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    n_cstart = sat21(off_w);
                    n_cend   = sat22(rest_w);
                    n_fstart = sat22(tot_w);
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_free <= 1'b0;
            r_do_size <= 1'b0;
        end else if (i_ctrl.decide) begin
            r_do_free <= n_do_free;
            r_do_size <= n_do_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.decide) begin
            r_status    <= n_status;
            r_msrc      <= n_msrc;
            r_mdst      <= n_mdst;
            r_mlen      <= n_mlen;
            r_waddr     <= n_waddr;
            r_cstart    <= n_cstart;
            r_cend      <= n_cend;
            r_fstart    <= n_fstart;
            r_rest      <= rest_w;
            r_after_sat <= sat_state(after_w);
            r_new_size  <= sat_state(round_w);
        end
    end

    // write port selection
    assign adj_hit = (WW'(r_rd_off) >= r_rest);

    always_comb begin
        we_off  = 1'b0;
        wa_off  = tgt_idx;
        wd_off  = r_after_sat;
        we_size = 1'b0;
        wa_size = tgt_idx;
        wd_size = '0;
        if ((r_dtag == TAG_ADJ) && adj_hit) begin
            we_off = 1'b1;
            wa_off = r_daddr;
            wd_off = r_rd_off - r_gap;
        end else if (i_ctrl.commit && r_do_free) begin
            we_off = 1'b1;
        end
        if (i_ctrl.commit && r_do_free) begin
            we_size = 1'b1;
        end else if (i_ctrl.commit && r_do_size) begin
            we_size = 1'b1;
            wa_size = r_recv;
            wd_size = r_new_size;
        end
    end

    // table write
    always_ff @(posedge i_clk) begin
        if (we_off) begin
            mem_off[wa_off] <= wd_off;
        end
        if (we_size) begin
            mem_size[wa_size] <= wd_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff  <= '0;
            r_vsize <= '0;
            r_recv  <= '0;
        end else begin
            if (we_off) begin
                r_voff[wa_off] <= 1'b1;
            end
            if (we_size) begin
                r_vsize[wa_size] <= 1'b1;
            end
            if (i_ctrl.commit && r_do_free) begin
                r_recv <= tgt_idx;
            end
        end
    end

    assign o_status        = r_status;
    assign o_move_source   = r_msrc;
    assign o_move_dest     = r_mdst;
    assign o_move_length   = r_mlen;
    assign o_write_address = r_waddr;
    assign o_span_start    = r_cstart;
    assign o_span_end      = r_cend;
    assign o_free_start    = r_fstart;

endmodule

FILE: verif/tb_program_slot_compacting_allocator.sv
`timescale 1ns / 100ps

module tb_program_slot_compacting_allocator;
    import psca_pkg::*;

    localparam int unsigned        SLOT_COUNT    = 8;
    localparam logic [W_CMD-1:0]   CMD_UNKNOWN   = 2'd3;
    localparam logic [W_BYTES-1:0] BYTES_MAX     = '1;
    localparam int unsigned        SETTLE_CYCLES = 30;
    localparam int unsigned        STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [W_CMD-1:0]   cmd;
        logic [W_SEL-1:0]   sel;
        logic [W_PID-1:0]   pid;
        logic               running;
        logic [W_BYTES-1:0] offset;
        logic [W_BYTES-1:0] count;
        logic               hold;
    } t_slot_request;

    typedef struct packed {
        logic [W_STATUS-1:0] status;
        logic [W_ADDR21-1:0] move_source;
        logic [W_ADDR21-1:0] move_dest;
        logic [W_ADDR21-1:0] move_length;
        logic [W_ADDR21-1:0] write_address;
        logic [W_ADDR21-1:0] span_start;
        logic [W_ADDR22-1:0] span_end;
        logic [W_ADDR22-1:0] free_start;
    } t_slot_reply;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  start             = 1'b0;
    logic                  busy;
    logic [W_CMD-1:0]      i_cmd             = '0;
    logic [W_SEL-1:0]      i_selected_slot   = '0;
    logic [W_PID-1:0]      i_program_id      = '0;
    logic                  i_program_running = 1'b0;
    logic [W_BYTES-1:0]    i_byte_offset     = '0;
    logic [W_BYTES-1:0]    i_byte_count      = '0;
    logic                  o_strobe;
    logic [W_STATUS-1:0]   o_status;
    logic [W_ADDR21-1:0]   o_move_source;
    logic [W_ADDR21-1:0]   o_move_dest;
    logic [W_ADDR21-1:0]   o_move_length;
    logic [W_ADDR21-1:0]   o_write_address;
    logic [W_ADDR21-1:0]   o_span_start;
    logic [W_ADDR22-1:0]   o_span_end;
    logic [W_ADDR22-1:0]   o_free_start;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [W_BYTES-1:0]    i_cfg_data        = '0;

    // predicted slot table and capacity
    logic [W_ADDR21-1:0]   model_offset [SLOT_COUNT];
    logic [W_ADDR21-1:0]   model_size   [SLOT_COUNT];
    int unsigned           model_receiving;
    logic [W_BYTES-1:0]    model_capacity;

    t_slot_request         pending_requests [$];
    t_slot_reply           awaited_replies  [$];
    t_slot_request         cur_req;
    int unsigned           gap_pct          = 0;
    int unsigned           queued           = 0;
    int unsigned           mismatches       = 0;
    int unsigned           requests_taken   = 0;
    int unsigned           replies_seen     = 0;
    int unsigned           moves_seen       = 0;
    int unsigned           writes_granted   = 0;
    int unsigned           capacity_writes  = 0;
    int unsigned           stall_cycles     = 0;

    program_slot_compacting_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_selected_slot   (i_selected_slot),
        .i_program_id      (i_program_id),
        .i_program_running (i_program_running),
        .i_byte_offset     (i_byte_offset),
        .i_byte_count      (i_byte_count),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_move_source     (o_move_source),
        .o_move_dest       (o_move_dest),
        .o_move_length     (o_move_length),
        .o_write_address   (o_write_address),
        .o_span_start      (o_span_start),
        .o_span_end        (o_span_end),
        .o_free_start      (o_free_start),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [W_ADDR21-1:0] clip21(input longint unsigned v);
        return (v > 64'(MAX21)) ? MAX21 : v[W_ADDR21-1:0];
    endfunction

    function automatic logic [W_ADDR22-1:0] clip22(input longint unsigned v);
        return (v > 64'(MAX22)) ? MAX22 : v[W_ADDR22-1:0];
    endfunction

    function automatic longint unsigned slots_in_use();
        longint unsigned sum;
        sum = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            sum += 64'(model_size[i]);
        end
        return sum;
    endfunction

    // predict the reply to one request and update the table copy
    function automatic t_slot_reply apply_slot_command(input t_slot_request rq);
        t_slot_reply     rp;
        longint unsigned total, gap, after, base, rest, count;
        int unsigned     s;
        int              i;
        rp        = '0;
        rp.status = ST_OK;
        count     = 64'(rq.count);
        case (rq.cmd)
            CMD_SET: begin
                if (rq.running) begin
                    rp.status = ST_BUSY;
                end else if (count == 0) begin
                    // free the selected slot, close the hole, park it at the end
                    s     = 32'(rq.sel);
                    total = slots_in_use();
                    gap   = 64'(model_size[s]);
                    base  = 64'(model_offset[s]);
                    after = total - gap;
                    model_receiving = s;
                    if (gap != 0 && base != after) begin
                        rest           = base + gap;
                        rp.move_source = clip21(rest);
                        rp.move_dest   = clip21(base);
                        rp.move_length = clip21((total >= rest) ? total - rest : 64'd0);
                        for (i = 0; i < SLOT_COUNT; i++) begin
                            if (64'(model_offset[i]) >= rest) begin
                                model_offset[i] = clip21(64'(model_offset[i]) - gap);
                            end
                        end
                    end
                    model_size[s]   = '0;
                    model_offset[s] = clip21(after);
                end else if (model_size[model_receiving] != 0) begin
                    rp.status = ST_FAILED;
                end else begin
                    // size rounded up to whole words
                    model_size[model_receiving] = clip21((count + 64'd3) / 64'd4 * 64'd4);
                end
            end
            CMD_WRITE: begin
                // bounds check ranks above the busy check
                base = 64'(model_offset[model_receiving]);
                if (base + 64'(rq.offset) + count > 64'(model_capacity)) begin
                    rp.status = ST_INVALID;
                end else if (rq.running) begin
                    rp.status = ST_BUSY;
                end else begin
                    rp.write_address = clip21(base + 64'(rq.offset));
                end
            end
            CMD_QUERY: begin
                s             = (rq.pid < SLOT_COUNT) ? 32'(rq.pid) : 32'(rq.sel);
                base          = 64'(model_offset[s]);
                rp.span_start = clip21(base);
                rp.span_end   = clip22(base + 64'(model_size[s]));
                rp.free_start = clip22(slots_in_use());
            end
            default: begin
                rp.status = ST_INVALID;
            end
        endcase
        return rp;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // request driver: presents queued requests with random idle gaps
    always @(posedge i_clk) begin
        logic        launch;
        t_slot_reply reply;
        launch = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                reply = apply_slot_command(cur_req);
                awaited_replies.push_back(reply);
                requests_taken++;
                if (cur_req.cmd == CMD_WRITE && reply.status == ST_OK) begin
                    writes_granted++;
                end
            end
            if (!start || !busy) begin
                if (pending_requests.size() != 0
                        && !(pending_requests[0].hold && awaited_replies.size() != 0)
                        && $urandom_range(99) >= gap_pct) begin
                    launch = 1'b1;
                end
            end
            if (launch) begin
                cur_req            = pending_requests.pop_front();
                i_cmd             <= cur_req.cmd;
                i_selected_slot   <= cur_req.sel;
                i_program_id      <= cur_req.pid;
                i_program_running <= cur_req.running;
                i_byte_offset     <= cur_req.offset;
                i_byte_count      <= cur_req.count;
                start             <= 1'b1;
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // reply monitor: each strobe against the oldest prediction
    always @(posedge i_clk) begin
        t_slot_reply want;
        if (i_rst_n && o_strobe) begin
            replies_seen++;
            if (o_move_length != 0) begin
                moves_seen++;
            end
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply with no request outstanding, expected none, actual status %0d",
                         $time, o_status);
                mismatches++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("move_source", 32'(want.move_source), 32'(o_move_source));
                check_field("move_dest", 32'(want.move_dest), 32'(o_move_dest));
                check_field("move_length", 32'(want.move_length), 32'(o_move_length));
                check_field("write_address", 32'(want.write_address), 32'(o_write_address));
                check_field("span_start", 32'(want.span_start), 32'(o_span_start));
                check_field("span_end", 32'(want.span_end), 32'(o_span_end));
                check_field("free_start", 32'(want.free_start), 32'(o_free_start));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_request(input logic [W_CMD-1:0] cmd, input logic [W_SEL-1:0] sel,
                                 input logic [W_PID-1:0] pid, input logic running,
                                 input logic [W_BYTES-1:0] offset,
                                 input logic [W_BYTES-1:0] count, input logic hold);
        t_slot_request rq;
        rq.cmd     = cmd;
        rq.sel     = sel;
        rq.pid     = pid;
        rq.running = running;
        rq.offset  = offset;
        rq.count   = count;
        rq.hold    = hold;
        pending_requests.push_back(rq);
        queued++;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || start || awaited_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [W_BYTES-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_capacity = value;
        capacity_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // one random phase: mostly load sequences, some noise
    task automatic run_phase(input logic [W_BYTES-1:0] capacity, input int unsigned idle_pct,
                             input int unsigned items);
        int unsigned        target;
        int unsigned        writes;
        logic [W_SEL-1:0]   sel;
        logic [W_BYTES-1:0] size, offset, count;
        wait_idle();
        write_capacity(capacity);
        gap_pct = idle_pct;
        target  = queued + items;
        while (queued < target) begin
            if ($urandom_range(9) < 7) begin
                // free a slot, size it, write into it, query it
                sel  = W_SEL'($urandom_range(SLOT_COUNT - 1));
                size = ($urandom_range(24) == 0) ? W_BYTES'($urandom_range(BYTES_MAX, 1))
                                                 : W_BYTES'($urandom_range(4096, 1));
                queue_request(CMD_SET, sel, W_PID'($urandom_range(255)),
                              $urandom_range(11) == 0, W_BYTES'($urandom_range(BYTES_MAX)),
                              '0, $urandom_range(7) == 0);
                queue_request(CMD_SET, W_SEL'($urandom_range(7)), W_PID'($urandom_range(255)),
                              $urandom_range(11) == 0, W_BYTES'($urandom_range(BYTES_MAX)),
                              size, 1'b0);
                writes = $urandom_range(3, 1);
                repeat (writes) begin
                    offset = W_BYTES'($urandom_range(size));
                    count  = ($urandom_range(7) == 0) ? W_BYTES'($urandom_range(BYTES_MAX))
                                                      : W_BYTES'($urandom_range(size - offset));
                    queue_request(CMD_WRITE, W_SEL'($urandom_range(7)),
                                  W_PID'($urandom_range(255)),
                                  $urandom_range(11) == 0, offset, count, 1'b0);
                end
                queue_request(CMD_QUERY, sel,
                              ($urandom_range(3) == 0) ? W_PID'($urandom_range(255))
                                                       : W_PID'(sel),
                              1'($urandom_range(1)), W_BYTES'($urandom_range(BYTES_MAX)),
                              W_BYTES'($urandom_range(BYTES_MAX)), 1'b0);
            end else begin
                queue_request(W_CMD'($urandom_range(3)), W_SEL'($urandom_range(7)),
                              W_PID'($urandom_range(255)),
                              1'($urandom_range(1)), W_BYTES'($urandom_range(BYTES_MAX)),
                              ($urandom_range(3) == 0) ? '0
                                                       : W_BYTES'($urandom_range(BYTES_MAX)),
                              1'b0);
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            model_offset[i] = '0;
            model_size[i]   = '0;
        end
        model_receiving = 0;
        model_capacity  = CAP_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: cleared table, field extremes, each command and corner
        queue_request(CMD_QUERY, 3'd0, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_QUERY, 3'd7, 8'd255, 1'b1, BYTES_MAX, BYTES_MAX, 1'b0);
        queue_request(CMD_UNKNOWN, 3'd7, 8'd255, 1'b0, BYTES_MAX, BYTES_MAX, 1'b0);
        queue_request(CMD_SET, 3'd0, 8'd0, 1'b1, '0, 20'd5, 1'b0);
        queue_request(CMD_SET, 3'd0, 8'd0, 1'b0, '0, BYTES_MAX, 1'b0);
        // second size into an occupied slot
        queue_request(CMD_SET, 3'd0, 8'd0, 1'b0, '0, 20'd8, 1'b0);
        // freeing an empty slot, sender holds off until the table settles
        queue_request(CMD_SET, 3'd1, 8'd0, 1'b0, '0, '0, 1'b1);
        queue_request(CMD_SET, 3'd1, 8'd0, 1'b0, '0, 20'd1048573, 1'b0);
        // offset saturates past the 21-bit range
        queue_request(CMD_SET, 3'd2, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd2, 8'd0, 1'b0, '0, 20'd1, 1'b0);
        queue_request(CMD_WRITE, 3'd0, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd0, 8'd0, 1'b1, '0, '0, 1'b0);
        // compaction moves
        queue_request(CMD_SET, 3'd0, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd1, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_QUERY, 3'd0, 8'd2, 1'b0, '0, '0, 1'b0);
        // stale offset beyond the used area: move of zero length
        queue_request(CMD_SET, 3'd2, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd7, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd7, 8'd0, 1'b0, '0, 20'd100, 1'b0);
        queue_request(CMD_SET, 3'd3, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd3, 8'd0, 1'b0, '0, 20'd20, 1'b0);
        // freeing the last used slot only parks it
        queue_request(CMD_SET, 3'd3, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_SET, 3'd3, 8'd0, 1'b0, '0, 20'd17, 1'b0);
        queue_request(CMD_WRITE, 3'd0, 8'd0, 1'b0, '0, '0, 1'b0);
        queue_request(CMD_WRITE, 3'd0, 8'd0, 1'b1, 20'd19, 20'd1, 1'b0);
        // out of bounds wins over busy
        queue_request(CMD_WRITE, 3'd0, 8'd0, 1'b1, BYTES_MAX, BYTES_MAX, 1'b0);
        // write ending exactly at the capacity
        queue_request(CMD_WRITE, 3'd0, 8'd0, 1'b0, 20'd1, 20'd262043, 1'b0);
        queue_request(CMD_QUERY, 3'd7, 8'd8, 1'b0, '0, '0, 1'b0);

        // random phases: capacity extremes and sender idle rates
        run_phase(BYTES_MAX, 0, 120);
        run_phase('0, 85, 120);
        // results cannot be stalled, so this phase runs back to back
        run_phase(W_BYTES'($urandom_range(BYTES_MAX - 1, 40000)), 0, 120);
        run_phase(CAP_RESET, 33, 120);

        wait_idle();
        $display("covered %0d requests and %0d replies, %0d compaction moves, %0d data writes",
                 requests_taken, replies_seen, moves_seen, writes_granted);
        $display("granted, %0d capacity settings, sender idle at 0, 85, 0 and 33 percent",
                 capacity_writes);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
